// File: design/amsgrad_pkg.sv
`timescale 1ns / 1ps

package amsgrad_pkg;

  localparam int unsigned DEF_NUM_ENTRIES = 32;

  localparam int IDX_W   = 5;
  localparam int DATA_W  = 32;
  localparam int COEF_W  = 24;

  localparam logic [COEF_W-1:0] LR_RESET = 24'd167772;
  localparam logic [COEF_W-1:0] B1_RESET = 24'd15099494;
  localparam logic [COEF_W-1:0] B2_RESET = 24'd16760439;
  localparam logic [COEF_W:0]   ONE_Q24  = 25'h1000000;
  localparam logic [COEF_W:0]   HALF_Q24 = 25'h0800000;

  // square root: 32 root bits, a few per stage
  localparam int ROOT_W     = 32;
  localparam int SQRT_STEPS = 4;
  localparam int SQ_STAGES  = ROOT_W / SQRT_STEPS;
  localparam int SQ_REM_W   = ROOT_W + 3;

  // divider: 48 quotient bits, a few per stage
  localparam int QUO_W     = 48;
  localparam int DVS_W     = ROOT_W + 1;
  localparam int DIV_STEPS = 4;
  localparam int DV_STAGES = QUO_W / DIV_STEPS;

  localparam int NUM_W = 56;

  typedef enum logic [1:0] {
    REG_LEARNING_RATE = 2'd0,
    REG_BETA_FIRST    = 2'd1,
    REG_BETA_SECOND   = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    OP_INIT = 1'b0,
    OP_STEP = 1'b1
  } op_t;

  typedef struct packed {
    logic             vld;
    op_t              op;
    logic [IDX_W-1:0] idx;
    logic             inr;
  } ctl_t;

  typedef struct packed {
    logic [DATA_W-1:0] p;
    logic              neg;
    logic [NUM_W-1:0]  num;
  } side_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [ROOT_W-1:0]   root;
    logic [63:0]         x;
  } sq_t;

  typedef struct packed {
    logic [DVS_W-1:0] rem;
    logic [QUO_W-1:0] quo;
    logic [DVS_W-1:0] dvs;
  } dv_t;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [49:0] x);
    if (x > 50'sd2147483647) return 32'h7FFF_FFFF;
    else if (x < -50'sd2147483648) return 32'h8000_0000;
    else return x[DATA_W-1:0];
  endfunction

  // digit-by-digit root, two radicand bits per step
  function automatic sq_t sqrt_steps(input sq_t s);
    sq_t                 r;
    logic [SQ_REM_W-1:0] t;
    logic [SQ_REM_W-1:0] trial;
    r = s;
    for (int i = 0; i < SQRT_STEPS; i++) begin
      t     = {r.rem[SQ_REM_W-3:0], r.x[63:62]};
      r.x   = {r.x[61:0], 2'b00};
      trial = {1'b0, r.root, 2'b01};
      if (t >= trial) begin
        r.rem  = t - trial;
        r.root = {r.root[ROOT_W-2:0], 1'b1};
      end else begin
        r.rem  = t;
        r.root = {r.root[ROOT_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // restoring division, one quotient bit per step
  function automatic dv_t div_steps(input dv_t s);
    dv_t              r;
    logic [DVS_W:0]   t;
    r = s;
    for (int i = 0; i < DIV_STEPS; i++) begin
      t     = {r.rem, r.quo[QUO_W-1]};
      r.quo = {r.quo[QUO_W-2:0], 1'b0};
      if (t >= {1'b0, r.dvs}) begin
        r.rem    = t[DVS_W-1:0] - r.dvs;
        r.quo[0] = 1'b1;
      end else begin
        r.rem = t[DVS_W-1:0];
      end
    end
    return r;
  endfunction

endpackage

// File: design/amsgrad_parameter_update_unit.sv
`timescale 1ns / 1ps

// AMSGrad parameter table, one optimizer step per item.
// Input channel (in_valid / in_stall): opcode OP_INIT writes the entry's parameter
// and clears its moments; OP_STEP applies a gradient. Every item returns one result
// item on the output channel (out_valid / out_stall) with the entry's new parameter.
// Configuration: cfg_we writes learning rate or betas by cfg_index. The user must
// use cfg_we only while idle; the block itself does not enforce this.
// Pipeline: 4 arithmetic stages, 9 root stages, 13 divider stages, output register.
// Root and divider each resolve 4 bits per stage.
// Throughput: one item per cycle while no entry is addressed again while still in
// flight and out_stall does not hold the pipeline. An item whose entry is still in
// flight is held off (in_stall) until the earlier item has written back, so
// back-to-back updates of one entry do not overlap.
// Reset clears all valid bits and loads the default registers; table contents are
// undefined until an init item writes them.
// When out_stall is high with a result waiting, the whole pipeline holds and
// in_stall rises; nothing is lost or repeated.

module amsgrad_parameter_update_unit
  import amsgrad_pkg::*;
#(
  parameter int unsigned NUM_ENTRIES = DEF_NUM_ENTRIES
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic                     in_opcode,
  input  logic [IDX_W-1:0]         in_entry_index,
  input  logic signed [DATA_W-1:0] in_operand_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [IDX_W-1:0]         out_result_index,
  output logic signed [DATA_W-1:0] out_param_value,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [COEF_W-1:0]        cfg_wdata
);

  localparam int AW = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

  logic [DATA_W-1:0] p_mem    [NUM_ENTRIES];
  logic [DATA_W-1:0] m_mem    [NUM_ENTRIES];
  logic [63:0]       v_mem    [NUM_ENTRIES];
  logic [63:0]       vmax_mem [NUM_ENTRIES];

  logic [COEF_W-1:0] lr_r, b1_r, b2_r;

  logic adv, hazard, acc, in_inr;
  logic out_valid_r;
  logic [IDX_W-1:0]  out_index_r;
  logic [DATA_W-1:0] out_value_r;

  // stage 1: table read data
  ctl_t              s1_ctl_r;
  logic signed [DATA_W-1:0] s1_g_r;
  logic [DATA_W-1:0] rd_p_r, rd_m_r;
  logic [63:0]       rd_v_r, rd_vmax_r;

  // stage 2: first products
  ctl_t              s2_ctl_r;
  logic signed [57:0] pm1_r, pm2_r;
  logic [63:0]       g2_r;
  logic [55:0]       vh2_r, vl2_r;
  logic [DATA_W-1:0] s2_p_r;
  logic [63:0]       s2_vmax_r;

  // stage 3: new first moment, gradient-square blend products
  ctl_t              s3_ctl_r;
  logic [DATA_W-1:0] s3_m_r;
  logic [55:0]       vh3_r, vl3_r;
  logic [56:0]       gh_r, gl_r;
  logic [DATA_W-1:0] s3_p_r;
  logic [63:0]       s3_vmax_r;

  // stage 4: new second moment, numerator
  ctl_t              s4_ctl_r;
  logic [63:0]       s4_v_r, s4_vmax_r;
  side_t             s4_sd_r;

  ctl_t  sq_ctl_r [SQ_STAGES+1];
  sq_t   sq_r     [SQ_STAGES+1];
  side_t sq_sd_r  [SQ_STAGES+1];

  ctl_t  dv_ctl_r [DV_STAGES+1];
  dv_t   dv_r     [DV_STAGES+1];
  side_t dv_sd_r  [DV_STAGES+1];

  // ---------------------------------------------------------------- control
  assign adv    = !out_valid_r || !out_stall;
  assign in_inr = (32'(in_entry_index) < NUM_ENTRIES);

  always_comb begin
    hazard = 1'b0;
    if (s1_ctl_r.vld && s1_ctl_r.idx == in_entry_index) hazard = 1'b1;
    if (s2_ctl_r.vld && s2_ctl_r.idx == in_entry_index) hazard = 1'b1;
    if (s3_ctl_r.vld && s3_ctl_r.idx == in_entry_index) hazard = 1'b1;
    if (s4_ctl_r.vld && s4_ctl_r.idx == in_entry_index) hazard = 1'b1;
    for (int k = 0; k <= SQ_STAGES; k++) begin
      if (sq_ctl_r[k].vld && sq_ctl_r[k].idx == in_entry_index) hazard = 1'b1;
    end
    for (int k = 0; k <= DV_STAGES; k++) begin
      if (dv_ctl_r[k].vld && dv_ctl_r[k].idx == in_entry_index) hazard = 1'b1;
    end
  end

  assign in_stall = !adv || hazard;
  assign acc      = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= LR_RESET;
      b1_r <= B1_RESET;
      b2_r <= B2_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LEARNING_RATE: lr_r <= cfg_wdata;
        REG_BETA_FIRST:    b1_r <= cfg_wdata;
        REG_BETA_SECOND:   b2_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- table
  logic [AW-1:0]     rd_addr;
  logic              m_we, v_we, vmax_we, p_we;
  logic [AW-1:0]     m_wa, v_wa, vmax_wa, p_wa;
  logic [DATA_W-1:0] m_wd, p_wd;
  logic [63:0]       v_wd, vmax_wd;

  assign rd_addr = AW'(in_entry_index);

  always_ff @(posedge clk) begin
    if (p_we) p_mem[p_wa] <= p_wd;
    if (adv) rd_p_r <= p_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (m_we) m_mem[m_wa] <= m_wd;
    if (adv) rd_m_r <= m_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (v_we) v_mem[v_wa] <= v_wd;
    if (adv) rd_v_r <= v_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vmax_we) vmax_mem[vmax_wa] <= vmax_wd;
    if (adv) rd_vmax_r <= vmax_mem[rd_addr];
  end

  // ---------------------------------------------------------------- stage 1
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else if (adv) begin
      s1_ctl_r <= '{vld: acc, op: op_t'(in_opcode), idx: in_entry_index, inr: in_inr};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) s1_g_r <= in_operand_value;
  end

  logic [COEF_W:0]    c1;
  logic [DATA_W-1:0]  gm;
  logic signed [57:0] pm1_nxt, pm2_nxt;
  logic [63:0]        g2_nxt;
  logic [55:0]        vh_nxt, vl_nxt;

  always_comb begin
    c1      = ONE_Q24 - {1'b0, b1_r};
    gm      = s1_g_r[DATA_W-1] ? DATA_W'(-s1_g_r) : DATA_W'(s1_g_r);
    pm1_nxt = $signed({1'b0, b1_r}) * $signed(rd_m_r);
    pm2_nxt = $signed({1'b0, c1}) * s1_g_r;
    g2_nxt  = {32'b0, gm} * {32'b0, gm};
    vh_nxt  = {24'b0, rd_v_r[63:32]} * {32'b0, b2_r};
    vl_nxt  = {24'b0, rd_v_r[31:0]} * {32'b0, b2_r};
  end

  // ---------------------------------------------------------------- stage 2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_ctl_r <= '0;
    end else if (adv) begin
      s2_ctl_r <= s1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pm1_r     <= pm1_nxt;
      pm2_r     <= pm2_nxt;
      g2_r      <= g2_nxt;
      vh2_r     <= vh_nxt;
      vl2_r     <= vl_nxt;
      s2_p_r    <= (s1_ctl_r.op == OP_STEP) ? rd_p_r : DATA_W'(s1_g_r);
      s2_vmax_r <= rd_vmax_r;
    end
  end

  logic [COEF_W:0]    c2;
  logic signed [57:0] msum;
  logic signed [33:0] mrnd;
  logic [DATA_W-1:0]  m_nxt;
  logic [56:0]        gh_nxt, gl_nxt;

  always_comb begin
    c2     = ONE_Q24 - {1'b0, b2_r};
    msum   = pm1_r + pm2_r + $signed({33'b0, HALF_Q24});
    mrnd   = msum[57:24];
    m_nxt  = sat32(50'(mrnd));
    gh_nxt = {25'b0, g2_r[63:32]} * {32'b0, c2};
    gl_nxt = {25'b0, g2_r[31:0]} * {32'b0, c2};
  end

  assign m_we = adv && s2_ctl_r.vld && s2_ctl_r.inr;
  assign m_wa = AW'(s2_ctl_r.idx);
  assign m_wd = (s2_ctl_r.op == OP_STEP) ? m_nxt : '0;

  // ---------------------------------------------------------------- stage 3
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r <= '0;
    end else if (adv) begin
      s3_ctl_r <= s2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_m_r    <= m_nxt;
      vh3_r     <= vh2_r;
      vl3_r     <= vl2_r;
      gh_r      <= gh_nxt;
      gl_r      <= gl_nxt;
      s3_p_r    <= s2_p_r;
      s3_vmax_r <= s2_vmax_r;
    end
  end

  logic [57:0]       hs, ls;
  logic [63:0]       v_nxt;
  logic [DATA_W-1:0] mm;
  logic [NUM_W-1:0]  num_nxt;

  always_comb begin
    hs      = {2'b0, vh3_r} + {1'b0, gh_r};
    ls      = {2'b0, vl3_r} + {1'b0, gl_r} + {33'b0, HALF_Q24};
    v_nxt   = {hs[55:0], 8'b0} + {30'b0, ls[57:24]};
    mm      = s3_m_r[DATA_W-1] ? (~s3_m_r + 32'd1) : s3_m_r;
    num_nxt = {24'b0, mm} * {32'b0, lr_r};
  end

  assign v_we = adv && s3_ctl_r.vld && s3_ctl_r.inr;
  assign v_wa = AW'(s3_ctl_r.idx);
  assign v_wd = (s3_ctl_r.op == OP_STEP) ? v_nxt : '0;

  // ---------------------------------------------------------------- stage 4
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_ctl_r <= '0;
    end else if (adv) begin
      s4_ctl_r <= s3_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_v_r    <= v_nxt;
      s4_vmax_r <= s3_vmax_r;
      s4_sd_r   <= '{p: s3_p_r, neg: s3_m_r[DATA_W-1], num: num_nxt};
    end
  end

  logic [63:0] vmax_nxt;
  assign vmax_nxt = (s4_vmax_r < s4_v_r) ? s4_v_r : s4_vmax_r;

  assign vmax_we = adv && s4_ctl_r.vld && s4_ctl_r.inr;
  assign vmax_wa = AW'(s4_ctl_r.idx);
  assign vmax_wd = (s4_ctl_r.op == OP_STEP) ? vmax_nxt : '0;

  // ---------------------------------------------------------------- square root
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_ctl_r[0] <= '0;
    end else if (adv) begin
      sq_ctl_r[0] <= s4_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r[0]    <= '{rem: '0, root: '0, x: vmax_nxt};
      sq_sd_r[0] <= s4_sd_r;
    end
  end

  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_ctl_r[k+1] <= '0;
      end else if (adv) begin
        sq_ctl_r[k+1] <= sq_ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_r[k+1]    <= sqrt_steps(sq_r[k]);
        sq_sd_r[k+1] <= sq_sd_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- divider
  // q = round(num / ((root + 1) * 256)), rounding folded into the dividend
  logic [DVS_W-1:0] dvs_nxt;
  logic [56:0]      nsum;

  always_comb begin
    dvs_nxt = {1'b0, sq_r[SQ_STAGES].root} + DVS_W'(1);
    nsum    = {1'b0, sq_sd_r[SQ_STAGES].num} + {17'b0, dvs_nxt, 7'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_ctl_r[0] <= '0;
    end else if (adv) begin
      dv_ctl_r[0] <= sq_ctl_r[SQ_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_r[0]    <= '{rem: '0, quo: nsum[55:8], dvs: dvs_nxt};
      dv_sd_r[0] <= sq_sd_r[SQ_STAGES];
    end
  end

  for (genvar k = 0; k < DV_STAGES; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_ctl_r[k+1] <= '0;
      end else if (adv) begin
        dv_ctl_r[k+1] <= dv_ctl_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_r[k+1]    <= div_steps(dv_r[k]);
        dv_sd_r[k+1] <= dv_sd_r[k];
      end
    end
  end

  // ---------------------------------------------------------------- write-back
  ctl_t               fin_ctl;
  side_t              fin_sd;
  logic signed [49:0] pe, qe, pn;
  logic [DATA_W-1:0]  p_nxt, res_nxt;

  always_comb begin
    fin_ctl = dv_ctl_r[DV_STAGES];
    fin_sd  = dv_sd_r[DV_STAGES];
    pe      = 50'($signed(fin_sd.p));
    qe      = $signed({2'b0, dv_r[DV_STAGES].quo});
    pn      = fin_sd.neg ? (pe + qe) : (pe - qe);
    p_nxt   = (fin_ctl.op == OP_STEP) ? sat32(pn) : fin_sd.p;
    res_nxt = fin_ctl.inr ? p_nxt : '0;
  end

  assign p_we = adv && fin_ctl.vld && fin_ctl.inr;
  assign p_wa = AW'(fin_ctl.idx);
  assign p_wd = p_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fin_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_index_r <= fin_ctl.idx;
      out_value_r <= res_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_index = out_index_r;
  assign out_param_value  = $signed(out_value_r);

  // ---------------------------------------------------------------- checks
  a_no_dup_front: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl_r.vld && s2_ctl_r.vld) |-> (s1_ctl_r.idx != s2_ctl_r.idx))
    else $error("same entry in two front stages");

  a_no_dup_back: assert property (@(posedge clk) disable iff (!rst_n)
    (sq_ctl_r[SQ_STAGES].vld && dv_ctl_r[DV_STAGES].vld) |->
      (sq_ctl_r[SQ_STAGES].idx != dv_ctl_r[DV_STAGES].idx))
    else $error("same entry in root and divider stages");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(s4_ctl_r) && $stable(dv_ctl_r[0])))
    else $error("pipeline moved while output stalled");

  a_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !(32'(out_index_r) < NUM_ENTRIES)) |-> (out_value_r == '0))
    else $error("out-of-range item returned nonzero value");

endmodule

// File: verif/amsgrad_parameter_update_unit_test.sv
`timescale 1ns / 1ps

module amsgrad_parameter_update_unit_test;
  import amsgrad_pkg::*;

  localparam int LATENCY = 27;
  localparam int N = DEF_NUM_ENTRIES;
  localparam logic [1:0] REG_SPARE = 2'd3;  // no register behind this index
  localparam logic signed [31:0] Q16_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q16_MIN = 32'sh8000_0000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_opcode;
  logic [IDX_W-1:0] in_entry_index;
  logic signed [DATA_W-1:0] in_operand_value;
  logic out_valid;
  logic out_stall;
  logic [IDX_W-1:0] out_result_index;
  logic signed [DATA_W-1:0] out_param_value;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [COEF_W-1:0] cfg_wdata;

  amsgrad_parameter_update_unit dut (.*);

  // predictor state
  logic signed [31:0] param_tbl [N];
  logic signed [31:0] mom1_tbl [N];
  logic [63:0] mom2_tbl [N];
  logic [63:0] mom2_max_tbl [N];
  bit inited [N];
  logic [23:0] lr_q;
  logic [23:0] b1_q;
  logic [23:0] b2_q;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic signed [31:0] value;
  } param_result_t;

  param_result_t pending_params[$];
  int errors = 0;
  bit idling_on = 1;
  int stall_left = 0;

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  function automatic logic signed [31:0] clamp_q16(input longint x);
    if (x > longint'(Q16_MAX)) return Q16_MAX;
    if (x < longint'(Q16_MIN)) return Q16_MIN;
    return x[31:0];
  endfunction

  function automatic logic [31:0] floor_root(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] v;
    v = x;
    r = 0;
    b = 64'h1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r[31:0];
  endfunction

  // one AMSGrad step (or entry init) on the predictor's table
  function automatic logic signed [31:0] amsgrad_update(input op_t op, input logic [4:0] idx,
                                                        input logic signed [31:0] val);
    longint m;
    longint p;
    longint g;
    longint acc1;
    logic [63:0] mag;
    logic [63:0] g2;
    logic [63:0] v;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] q;
    logic [127:0] acc2;
    if (op == OP_INIT) begin
      param_tbl[idx] = val;
      mom1_tbl[idx] = 0;
      mom2_tbl[idx] = 0;
      mom2_max_tbl[idx] = 0;
      return val;
    end
    g = val;
    m = mom1_tbl[idx];
    acc1 = longint'(b1_q) * m + (longint'(ONE_Q24) - longint'(b1_q)) * g;
    m = clamp_q16((acc1 + longint'(HALF_Q24)) >>> 24);
    mom1_tbl[idx] = m[31:0];
    mag = (g < 0) ? -g : g;
    g2 = mag * mag;
    acc2 = 128'(b2_q) * 128'(mom2_tbl[idx]) + (128'(ONE_Q24) - 128'(b2_q)) * 128'(g2)
           + 128'(HALF_Q24);
    v = acc2[87:24];
    mom2_tbl[idx] = v;
    if (mom2_max_tbl[idx] < v) mom2_max_tbl[idx] = v;
    den = (64'(floor_root(mom2_max_tbl[idx])) + 64'd1) << 8;
    num = 64'(lr_q) * 64'((m < 0) ? -m : m);
    q = (num + (den >> 1)) / den;
    p = param_tbl[idx];
    if (m < 0) p = p + longint'(q);
    else p = p - longint'(q);
    param_tbl[idx] = clamp_q16(p);
    return param_tbl[idx];
  endfunction

  // result check
  always @(posedge clk) begin
    param_result_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_params.size() == 0) begin
        $error("unexpected result item: result_index %0d param_value %0d",
               out_result_index, out_param_value);
        errors++;
      end else begin
        exp_r = pending_params.pop_front();
        if (out_result_index !== exp_r.idx) begin
          $error("result_index: expected %0d, got %0d", exp_r.idx, out_result_index);
          errors++;
        end
        if (out_param_value !== exp_r.value) begin
          $error("param_value: expected %0d, got %0d", exp_r.value, out_param_value);
          errors++;
        end
      end
    end
  end

  // receiver stall bursts
  always @(posedge clk) begin
    if (!idling_on || !rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (out_stall) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 10);
    end
  end

  task automatic send_item(input op_t op, input logic [4:0] idx, input logic signed [31:0] val);
    param_result_t r;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_entry_index <= idx;
    in_operand_value <= val;
    do @(posedge clk); while (in_stall);
    r.idx = idx;
    r.value = amsgrad_update(op, idx, val);
    if (op == OP_INIT) inited[idx] = 1;
    pending_params = {pending_params, r};
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_params.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [23:0] data);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LEARNING_RATE: lr_q = data;
      REG_BETA_FIRST: b1_q = data;
      REG_BETA_SECOND: b2_q = data;
      default: ;
    endcase
  endtask

  function automatic logic signed [31:0] pick_gradient();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return Q16_MAX;
      2: return Q16_MIN;
      3: return $signed($urandom_range(0, 7)) - 3;
      default: return $signed($urandom_range(0, 32'h4_0000)) - 32'sh2_0000;
    endcase
  endfunction

  task automatic random_items(input int count);
    logic [4:0] idx;
    for (int i = 0; i < N; i++)
      if (!inited[i]) send_item(OP_INIT, IDX_W'(i), $urandom);
    for (int i = 0; i < count; i++) begin
      // clustered entries to hit same-entry hazards now and then
      idx = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 3))
                                        : IDX_W'($urandom_range(0, N - 1));
      if ($urandom_range(0, 9) == 0) send_item(OP_INIT, idx, pick_gradient());
      else send_item(OP_STEP, idx, pick_gradient());
    end
  endtask

  task automatic test_directed();
    send_item(OP_INIT, 0, 32'sd0);
    send_item(OP_INIT, 31, Q16_MAX);
    send_item(OP_INIT, 1, Q16_MIN);
    send_item(OP_INIT, 2, 32'sh0001_0000);
    send_item(OP_INIT, 3, -32'sd1);
    send_item(OP_STEP, 0, 32'sd0);
    send_item(OP_STEP, 31, Q16_MIN);  // drives toward positive saturation
    send_item(OP_STEP, 1, Q16_MAX);
    send_item(OP_STEP, 2, 32'sd1);
    send_item(OP_STEP, 3, -32'sd1);
    // back-to-back on one entry
    send_item(OP_STEP, 2, 32'sh0002_0000);
    send_item(OP_STEP, 2, -32'sh0002_0000);
    send_item(OP_STEP, 2, 32'sh0000_8000);
    send_item(OP_STEP, 31, Q16_MIN);
    send_item(OP_STEP, 1, Q16_MAX);
    send_item(OP_INIT, 2, -32'sh0005_0000);
    send_item(OP_STEP, 2, $urandom);
  endtask

  task automatic test_quiet_sender();
    random_items(30);
    wait_drained();
    random_items(30);
  endtask

  task automatic test_coefficient_extremes();
    write_reg(REG_LEARNING_RATE, 24'hFF_FFFF);
    write_reg(REG_BETA_FIRST, 24'd0);
    write_reg(REG_BETA_SECOND, 24'hFF_FFFF);
    random_items(120);
    write_reg(REG_LEARNING_RATE, 24'd0);
    write_reg(REG_BETA_FIRST, 24'hFF_FFFF);
    write_reg(REG_BETA_SECOND, 24'd0);
    random_items(100);
    write_reg(REG_SPARE, 24'hFF_FFFF);
    write_reg(REG_LEARNING_RATE, COEF_W'($urandom));
    write_reg(REG_BETA_FIRST, COEF_W'($urandom));
    write_reg(REG_BETA_SECOND, COEF_W'($urandom));
    random_items(100);
    write_reg(REG_LEARNING_RATE, LR_RESET);
    write_reg(REG_BETA_FIRST, B1_RESET);
    write_reg(REG_BETA_SECOND, B2_RESET);
  endtask

  task automatic test_full_rate();
    random_items(150);
    wait_drained();
    idling_on = 0;
    random_items(100);
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = 1'b0;
    in_entry_index = '0;
    in_operand_value = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    lr_q = LR_RESET;
    b1_q = B1_RESET;
    b2_q = B2_RESET;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_quiet_sender();
    test_coefficient_extremes();
    test_full_rate();
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0) $display("amsgrad_parameter_update_unit_test passed");
    else $display("amsgrad_parameter_update_unit_test failed");
    $finish;
  end

  initial begin
    #2000000;
    $display("amsgrad_parameter_update_unit_test failed");
    $finish;
  end

endmodule

// File: files.f
design/amsgrad_pkg.sv
design/amsgrad_parameter_update_unit.sv
verif/amsgrad_parameter_update_unit_test.sv
